// ===== hdl/spr_pkg.sv =====
// shared types and constants for the serial packet receiver
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

    localparam logic [7:0] ACK_SUM = 8'hCC;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic [1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_BAD_SUM = 2'd1;
    localparam t_status ST_BAD_LEN = 2'd2;

    typedef struct packed {
        logic       packet_end;
        logic [7:0] payload_byte;
        logic [7:0] command_code;
        logic       has_command;
        logic       ack_packet;
        t_status    status_code;
        logic [7:0] payload_count;
    } t_item;

endpackage

`default_nettype wire

// ===== hdl/serial_packet_receiver_top.sv =====
// serial packet receiver: byte-serial deframer for length/checksum packets
//
// input channel: i_in_valid / o_in_stall carry one received byte per word on
// i_rx_byte. a packet is length, checksum, command, then payload bytes.
// output channel: o_out_valid / i_out_stall carry one result word: a payload
// word per payload byte and a summary word (o_packet_end high) at the end of
// each packet, with command, payload count, ack flag and status.
// a word is taken at a rising edge with valid high and stall low. a result
// word enters the output queue when its byte is taken. throughput: one byte
// per cycle while o_in_stall is low; the last payload byte of a packet makes
// two result words, which drain from a four-word output queue one per cycle
// while i_out_stall is low. o_in_stall rises when that queue cannot hold two
// more words, so a stalled receiver backs up into the input once three or
// four words are waiting. reset (synchronous, active low) empties the queue
// and returns the deframer to waiting for a length byte.
`timescale 1ns / 1ps
`default_nettype none

module serial_packet_receiver_top
    import spr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_packet_end,
    output logic [7:0]      o_payload_byte,
    output logic [7:0]      o_command_code,
    output logic            o_has_command,
    output logic            o_ack_packet,
    output logic [1:0]      o_status_code,
    output logic [7:0]      o_payload_count
);

    typedef enum logic [1:0] {
        PH_LEN = 2'd0,
        PH_SUM = 2'd1,
        PH_CMD = 2'd2,
        PH_PAY = 2'd3
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_len, n_len;
    logic [7:0] r_rsum, n_rsum;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_cmd, n_cmd;

    t_item      r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count, n_count;

    logic       in_acc, out_acc;
    logic [1:0] push;
    t_item      item0, item1;
    logic [7:0] sum_new, pos_new;
    t_item      head;

    assign o_in_stall  = (r_count > CNT_W'(FIFO_DEPTH - 2));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign out_acc     = o_out_valid && !i_out_stall;

    assign sum_new = r_sum + i_rx_byte;
    assign pos_new = r_pos + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_rsum  = r_rsum;
        n_sum   = r_sum;
        n_pos   = r_pos;
        n_cmd   = r_cmd;
        item0   = '0;
        item1   = '0;
        push    = 2'd0;
        if (in_acc) begin
            case (r_phase)
                PH_LEN: begin
                    n_len  = i_rx_byte;
                    n_sum  = '0;
                    n_rsum = '0;
                    n_cmd  = '0;
                    n_pos  = 8'd1;
                    if (i_rx_byte == 8'd1) begin
                        item0.packet_end  = 1'b1;
                        item0.status_code = ST_BAD_LEN;
                        push    = 2'd1;
                        n_pos   = '0;
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    n_rsum = i_rx_byte;
                    n_pos  = 8'd2;
                    if (r_len == 8'd0) begin
                        item0.packet_end  = 1'b1;
                        item0.ack_packet  = 1'b1;
                        item0.status_code = (i_rx_byte == ACK_SUM) ? ST_OK : ST_BAD_SUM;
                        push    = 2'd1;
                        n_pos   = '0;
                        n_phase = PH_LEN;
                    end else if (r_len == 8'd2) begin
                        item0.packet_end  = 1'b1;
                        item0.status_code = (r_sum == i_rx_byte) ? ST_OK : ST_BAD_SUM;
                        push    = 2'd1;
                        n_pos   = '0;
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    n_cmd = i_rx_byte;
                    n_sum = sum_new;
                    n_pos = 8'd3;
                    if (r_len == 8'd3) begin
                        item0.packet_end   = 1'b1;
                        item0.command_code = i_rx_byte;
                        item0.has_command  = 1'b1;
                        item0.status_code  = (sum_new == r_rsum) ? ST_OK : ST_BAD_SUM;
                        push    = 2'd1;
                        n_pos   = '0;
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = PH_PAY;
                    end
                end
                PH_PAY: begin
                    n_sum = sum_new;
                    n_pos = pos_new;
                    item0.payload_byte = i_rx_byte;
                    item0.command_code = r_cmd;
                    item0.has_command  = 1'b1;
                    push = 2'd1;
                    if (pos_new == r_len) begin
                        item1.packet_end    = 1'b1;
                        item1.command_code  = r_cmd;
                        item1.has_command   = 1'b1;
                        item1.status_code   = (sum_new == r_rsum) ? ST_OK : ST_BAD_SUM;
                        item1.payload_count = r_len - 8'd3;
                        push    = 2'd2;
                        n_pos   = '0;
                        n_phase = PH_LEN;
                    end
                end
                default: begin
                    n_phase = PH_LEN;
                end
            endcase
        end
    end

    assign n_count = r_count + CNT_W'(push) - CNT_W'(out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_len   <= '0;
            r_rsum  <= '0;
            r_sum   <= '0;
            r_pos   <= '0;
            r_cmd   <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_rsum  <= n_rsum;
            r_sum   <= n_sum;
            r_pos   <= n_pos;
            r_cmd   <= n_cmd;
            r_wr    <= r_wr + PTR_W'(push);
            r_rd    <= r_rd + PTR_W'(out_acc);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_mem[r_wr] <= item0;
        end
        if (push == 2'd2) begin
            r_mem[r_wr + PTR_W'(1)] <= item1;
        end
    end

    assign head            = r_mem[r_rd];
    assign o_packet_end    = head.packet_end;
    assign o_payload_byte  = head.payload_byte;
    assign o_command_code  = head.command_code;
    assign o_has_command   = head.has_command;
    assign o_ack_packet    = head.ack_packet;
    assign o_status_code   = head.status_code;
    assign o_payload_count = head.payload_count;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_packet_end) |-> (o_payload_byte == 8'd0))
        else $error("summary word carries a payload byte");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_packet_end)
            |-> (!o_ack_packet && o_status_code == ST_OK && o_payload_count == 8'd0))
        else $error("payload word carries summary fields");

    a_len_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_LEN && i_rx_byte != 8'd1) |=> (r_phase == PH_SUM))
        else $error("length byte did not advance to checksum");

    a_no_push_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> (r_count <= $past(r_count)))
        else $error("queue grew without an input byte");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_serial_packet_receiver_top.sv =====
// self-checking testbench for the serial packet receiver deframer
`timescale 1ns / 1ps

module tb_serial_packet_receiver_top;
    import spr_pkg::*;

    localparam int RANDOM_BYTES = 130;
    localparam int TAIL_WORDS   = 60;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_CHECK,
        PH_COMMAND,
        PH_PAYLOAD
    } t_rx_phase;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_rx_byte = 8'd0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_packet_end;
    logic [7:0] o_payload_byte;
    logic [7:0] o_command_code;
    logic       o_has_command;
    logic       o_ack_packet;
    logic [1:0] o_status_code;
    logic [7:0] o_payload_count;

    logic [7:0] byte_q[$];
    t_item      expected_words[$];
    int         bad_words = 0;
    int         in_gap = 0;
    int         out_gap = 0;

    t_rx_phase  rx_phase = PH_LENGTH;
    logic [7:0] frame_len = 8'd0;
    logic [7:0] frame_check = 8'd0;
    logic [7:0] frame_sum = 8'd0;
    logic [7:0] frame_pos = 8'd0;
    logic [7:0] frame_cmd = 8'd0;

    serial_packet_receiver_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_packet_end   (o_packet_end),
        .o_payload_byte (o_payload_byte),
        .o_command_code (o_command_code),
        .o_has_command  (o_has_command),
        .o_ack_packet   (o_ack_packet),
        .o_status_code  (o_status_code),
        .o_payload_count(o_payload_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_item summary_word(input logic [7:0] cmd, input logic has_cmd,
                                           input logic ack, input t_status st,
                                           input logic [7:0] cnt);
        return {1'b1, 8'd0, cmd, has_cmd, ack, st, cnt};
    endfunction

    function automatic t_status sum_verdict();
        return (frame_sum == frame_check) ? ST_OK : ST_BAD_SUM;
    endfunction

    function automatic string word_text(input t_item w);
        return $sformatf("end=%0d pay=%h cmd=%h has=%0d ack=%0d st=%0d cnt=%0d",
                         w.packet_end, w.payload_byte, w.command_code, w.has_command,
                         w.ack_packet, w.status_code, w.payload_count);
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        case (rx_phase)
            PH_LENGTH: begin
                frame_len   = b;
                frame_sum   = 8'd0;
                frame_check = 8'd0;
                frame_cmd   = 8'd0;
                frame_pos   = 8'd1;
                if (b == 8'd1) begin
                    expected_words.push_back(summary_word(8'd0, 1'b0, 1'b0, ST_BAD_LEN, 8'd0));
                    frame_pos = 8'd0;
                end else begin
                    rx_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                frame_check = b;
                frame_pos   = 8'd2;
                if (frame_len == 8'd0) begin
                    expected_words.push_back(summary_word(8'd0, 1'b0, 1'b1,
                        (b == ACK_SUM) ? ST_OK : ST_BAD_SUM, 8'd0));
                    rx_phase  = PH_LENGTH;
                    frame_pos = 8'd0;
                end else if (frame_len == 8'd2) begin
                    expected_words.push_back(summary_word(8'd0, 1'b0, 1'b0,
                        sum_verdict(), 8'd0));
                    rx_phase  = PH_LENGTH;
                    frame_pos = 8'd0;
                end else begin
                    rx_phase = PH_COMMAND;
                end
            end
            PH_COMMAND: begin
                frame_cmd = b;
                frame_sum = frame_sum + b;
                frame_pos = 8'd3;
                if (frame_len == 8'd3) begin
                    expected_words.push_back(summary_word(frame_cmd, 1'b1, 1'b0,
                        sum_verdict(), 8'd0));
                    rx_phase  = PH_LENGTH;
                    frame_pos = 8'd0;
                end else begin
                    rx_phase = PH_PAYLOAD;
                end
            end
            default: begin
                frame_sum = frame_sum + b;
                frame_pos = frame_pos + 8'd1;
                expected_words.push_back({1'b0, b, frame_cmd, 1'b1, 1'b0, ST_OK, 8'd0});
                if (frame_pos == frame_len) begin
                    expected_words.push_back(summary_word(frame_cmd, 1'b1, 1'b0,
                        sum_verdict(), frame_len - 8'd3));
                    rx_phase  = PH_LENGTH;
                    frame_pos = 8'd0;
                end
            end
        endcase
    endtask

    // builds one packet with random content, keeping only its first keep bytes
    task automatic queue_packet(input int len, input bit good_sum, input int keep);
        logic [7:0] frame[$];
        logic [7:0] sum;
        logic [7:0] chk_byte;
        sum = 8'd0;
        if (len >= 3) begin
            for (int i = 0; i < len - 2; i++) begin
                frame.push_back(8'($urandom_range(0, 255)));
                sum = sum + frame[i];
            end
        end
        if (len == 0) begin
            chk_byte = good_sum ? ACK_SUM : ACK_SUM ^ 8'($urandom_range(1, 255));
        end else begin
            chk_byte = good_sum ? sum : sum ^ 8'($urandom_range(1, 255));
        end
        if (len != 1) begin
            frame.push_front(chk_byte);
        end
        frame.push_front(8'(len));
        for (int i = 0; i < frame.size() && i < keep; i++) begin
            byte_q.push_back(frame[i]);
        end
    endtask

    always @(posedge i_clk) begin : drive_in
        logic       next_valid;
        logic [7:0] next_byte;
        next_valid = i_in_valid;
        next_byte  = i_rx_byte;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                deframe_byte(i_rx_byte);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (byte_q.size() >= TAIL_WORDS && $urandom_range(0, 9) == 0) begin
                    in_gap = $urandom_range(0, 13);
                end else if (byte_q.size() > 0) begin
                    next_valid = 1'b1;
                    next_byte  = byte_q.pop_front();
                end
            end
        end
        i_in_valid <= next_valid;
        i_rx_byte  <= next_byte;
    end

    always @(posedge i_clk) begin : watch_out
        t_item got;
        t_item want;
        logic  next_stall;
        next_stall = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_packet_end, o_payload_byte, o_command_code, o_has_command,
                       o_ack_packet, o_status_code, o_payload_count};
                if (expected_words.size() == 0) begin
                    bad_words++;
                    if (bad_words <= 10) begin
                        $display("unexpected result word: %s", word_text(got));
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        bad_words++;
                        if (bad_words <= 10) begin
                            $display("mismatch: expected %s", word_text(want));
                            $display("          actual   %s", word_text(got));
                        end
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                next_stall = 1'b1;
            end else if (byte_q.size() >= TAIL_WORDS && $urandom_range(0, 9) == 0) begin
                out_gap    = $urandom_range(0, 13);
                next_stall = 1'b1;
            end
        end
        i_out_stall <= next_stall;
    end

    initial begin
        int pick;
        int target;
        // acknowledge, good and bad
        byte_q.push_back(8'h00); byte_q.push_back(8'hCC);
        byte_q.push_back(8'h00); byte_q.push_back(8'h00);
        // length one
        byte_q.push_back(8'h01);
        // length two, good and bad
        byte_q.push_back(8'h02); byte_q.push_back(8'h00);
        byte_q.push_back(8'h02); byte_q.push_back(8'hFF);
        // command only, good and bad
        byte_q.push_back(8'h03); byte_q.push_back(8'hFF); byte_q.push_back(8'hFF);
        byte_q.push_back(8'h03); byte_q.push_back(8'h00); byte_q.push_back(8'h80);
        // two payload bytes at the extremes
        byte_q.push_back(8'h05); byte_q.push_back(8'h7F); byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF); byte_q.push_back(8'h80);

        queue_packet(255, 1'b1, 1000);
        target = byte_q.size() + RANDOM_BYTES;
        while (byte_q.size() < target) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                queue_packet($urandom_range(3, 12), 1'b1, $urandom_range(1, 3));
            end else if (pick <= 3) begin
                queue_packet($urandom_range(0, 2), $urandom_range(0, 1) != 0, 1000);
            end else begin
                queue_packet($urandom_range(3, 14), $urandom_range(0, 4) != 0, 1000);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (bad_words == 0 && expected_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/spr_pkg.sv
hdl/serial_packet_receiver_top.sv
dv/tb_serial_packet_receiver_top.sv
